@@ sv/assert_macros.svh @@
// Assertion macros shared by the matcher RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of clock, skipped during reset.
`define TMM_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check an implication on the rising edge of clock, skipped during reset.
`define TMM_ASSERT_IMPL(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

@@ sv/tmm_pkg.sv @@
// Package for the threshold multi-term matcher: request codes, register
// indexes, default sizes and the case-fold function. No dependencies.
`default_nettype none
package tmm_pkg;
   localparam int DEF_MAX_TERMS    = 64;
   localparam int DEF_MAX_TERM_LEN = 32;
   localparam int LEN_W            = 6;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_DATA   = 2'd1,
      REQ_EOS    = 2'd2,
      REQ_EOR    = 2'd3
   } req_code_type;

   localparam logic [1:0] CSR_REQUIRED_COUNT = 2'd0;
   localparam logic [1:0] CSR_IGNORE_CASE    = 2'd1;
   localparam logic [1:0] CSR_TERM_COUNT     = 2'd2;

   localparam logic [6:0] RESET_REQUIRED_COUNT = 7'd4;

   // Fold ASCII lower case to upper case when enabled.
   function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
      if (ic && c >= 8'h61 && c <= 8'h7a) begin
         return c - 8'h20;
      end
      return c;
   endfunction
endpackage
`default_nettype wire

@@ sv/tmm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ sv/threshold_multi_term_matcher_core.sv @@
// Threshold multi-term matcher. Terms load one byte per transfer into a
// byte RAM and a length RAM. Each data byte enters a window register and is
// then checked term by term: a length read state, a length check state,
// then the compare state once per term byte read from the byte RAM, which
// has a single read port. Loads and end of string are handled in idle.
// End of record sweeps the found flags of the terms in use and leaves the
// result in an output register.
// Depends on tmm_pkg, tmm_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module threshold_multi_term_matcher_core #(
   parameter int MAX_TERMS    = tmm_pkg::DEF_MAX_TERMS,
   parameter int MAX_TERM_LEN = tmm_pkg::DEF_MAX_TERM_LEN
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_type,
   input  wire logic [5:0] req_term_index,
   input  wire logic [4:0] req_char_pos,
   input  wire logic [7:0] req_byte_value,
   input  wire logic       req_term_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_verdict,
   output logic [6:0]      rsp_found_count,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [6:0] csr_data
);
   import tmm_pkg::*;

   localparam int TIW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int PW  = (MAX_TERM_LEN > 1) ? $clog2(MAX_TERM_LEN) : 1;
   localparam int TW  = $clog2(MAX_TERMS + 1);
   localparam int BW  = $clog2(MAX_TERM_LEN + 1);
   localparam int TB_DEPTH = MAX_TERMS * (2 ** PW);

   typedef enum logic [2:0] {
      S_IDLE, S_LEN, S_CHK, S_CMP, S_SWEEP
   } state_type;

   state_type          state_ff, state_in;
   logic [6:0]         req_count_ff, req_count_in;
   logic               ignore_case_ff, ignore_case_in;
   logic [6:0]         term_count_ff, term_count_in;
   logic [7:0]         win_ff [MAX_TERM_LEN];
   logic [7:0]         win_in [MAX_TERM_LEN];
   logic [BW-1:0]      bis_ff, bis_in;
   logic [MAX_TERMS-1:0] found_ff, found_in;
   logic [TW-1:0]      t_ff, t_in;
   logic [TW-1:0]      cnt_ff, cnt_in;
   logic [PW-1:0]      k_ff, k_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               verdict_ff, verdict_in;
   logic [6:0]         count_ff, count_in;

   logic [TW-1:0]      n_w;
   logic               req_acc;
   logic               ld_ok;
   logic               tb_we, len_we;
   logic [TIW+PW-1:0]  tb_waddr, tb_raddr;
   logic [7:0]         tb_rdata;
   logic [LEN_W-1:0]   len_rdata;
   logic [PW-1:0]      widx;
   logic               byte_match, last_byte, skip_term, last_term;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_found_count = count_ff;

   assign n_w = (32'(term_count_ff) > MAX_TERMS) ? TW'(MAX_TERMS) : TW'(term_count_ff);
   assign ld_ok = (32'(req_term_index) < MAX_TERMS) && (32'(req_char_pos) < MAX_TERM_LEN);

   // Term load writes.
   assign tb_we    = req_acc && (req_type == REQ_LOAD) && ld_ok;
   assign len_we   = tb_we && req_term_end;
   assign tb_waddr = {TIW'(req_term_index), PW'(req_char_pos)};
   assign tb_raddr = (state_ff == S_CMP) ? {t_ff[TIW-1:0], PW'(32'(k_ff) + 1)}
                                         : {t_ff[TIW-1:0], PW'(0)};

   tmm_ram #(.WIDTH(8), .DEPTH(TB_DEPTH)) u_bytes (
      .clock(clock), .wr_en(tb_we), .wr_addr(tb_waddr), .wr_data(req_byte_value),
      .rd_addr(tb_raddr), .rd_data(tb_rdata)
   );

   tmm_ram #(.WIDTH(LEN_W), .DEPTH(MAX_TERMS)) u_lengths (
      .clock(clock), .wr_en(len_we), .wr_addr(TIW'(req_term_index)),
      .wr_data(LEN_W'(req_char_pos) + LEN_W'(1)),
      .rd_addr(t_ff[TIW-1:0]), .rd_data(len_rdata)
   );

   // Compare terms against the window.
   assign widx       = PW'(32'(len_ff) - 1 - 32'(k_ff));
   assign byte_match = fold(tb_rdata, ignore_case_ff) == fold(win_ff[widx], ignore_case_ff);
   assign last_byte  = (32'(k_ff) + 1) == 32'(len_ff);
   assign skip_term  = found_ff[t_ff[TIW-1:0]] || (len_rdata == '0)
                       || (32'(len_rdata) > MAX_TERM_LEN) || (32'(len_rdata) > 32'(bis_ff));
   assign last_term  = (32'(t_ff) + 1) >= 32'(n_w);

   // Next state.
   always_comb begin
      state_in       = state_ff;
      req_count_in   = req_count_ff;
      ignore_case_in = ignore_case_ff;
      term_count_in  = term_count_ff;
      win_in         = win_ff;
      bis_in         = bis_ff;
      found_in       = found_ff;
      t_in           = t_ff;
      cnt_in         = cnt_ff;
      k_in           = k_ff;
      len_in         = len_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      verdict_in     = verdict_ff;
      count_in       = count_ff;

      // Register writes.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_REQUIRED_COUNT: req_count_in   = csr_data;
            CSR_IGNORE_CASE:    ignore_case_in = csr_data[0];
            CSR_TERM_COUNT:     term_count_in  = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_type)
                  REQ_DATA: begin
                     for (int i = MAX_TERM_LEN - 1; i > 0; i--) begin
                        win_in[i] = win_ff[i-1];
                     end
                     win_in[0] = req_byte_value;
                     if (32'(bis_ff) < MAX_TERM_LEN) begin
                        bis_in = bis_ff + BW'(1);
                     end
                     t_in = '0;
                     if (n_w != '0) begin
                        state_in = S_LEN;
                     end
                  end
                  REQ_EOS: bis_in = '0;
                  REQ_EOR: begin
                     bis_in   = '0;
                     t_in     = '0;
                     cnt_in   = '0;
                     state_in = S_SWEEP;
                  end
                  default: ;
               endcase
            end
         end
         S_LEN: state_in = S_CHK;
         S_CHK: begin
            len_in = len_rdata;
            k_in   = '0;
            if (skip_term) begin
               t_in     = t_ff + TW'(1);
               state_in = last_term ? S_IDLE : S_LEN;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (byte_match && !last_byte) begin
               k_in = k_ff + PW'(1);
            end else begin
               if (byte_match) begin
                  found_in[t_ff[TIW-1:0]] = 1'b1;
               end
               t_in     = t_ff + TW'(1);
               state_in = last_term ? S_IDLE : S_LEN;
            end
         end
         S_SWEEP: begin
            if (t_ff < n_w) begin
               cnt_in = cnt_ff + TW'(found_ff[t_ff[TIW-1:0]]);
               t_in   = t_ff + TW'(1);
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               verdict_in   = (n_w == '0) ||
                              ((cnt_ff != '0) && (32'(cnt_ff) >= 32'(req_count_ff)));
               count_in     = 7'(cnt_ff);
               found_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state; reset control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         req_count_ff   <= RESET_REQUIRED_COUNT;
         ignore_case_ff <= 1'b0;
         term_count_ff  <= '0;
         bis_ff         <= '0;
         found_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < MAX_TERM_LEN; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         req_count_ff   <= req_count_in;
         ignore_case_ff <= ignore_case_in;
         term_count_ff  <= term_count_in;
         bis_ff         <= bis_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
         win_ff         <= win_in;
      end
      t_ff       <= t_in;
      cnt_ff     <= cnt_in;
      k_ff       <= k_in;
      len_ff     <= len_in;
      verdict_ff <= verdict_in;
      count_ff   <= count_in;
   end

   `TMM_ASSERT(a_idle_flags_hold, (state_ff == S_IDLE) |=> $stable(found_ff), "flags moved in idle")
   `TMM_ASSERT_IMPL(a_cmp_in_term, state_ff == S_CMP, 32'(k_ff) < 32'(len_ff), "byte index past term")
   `TMM_ASSERT_IMPL(a_count_range, rsp_valid_ff, 32'(count_ff) <= MAX_TERMS, "found count too big")
endmodule
`default_nettype wire
